>>> hw/rtl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants and types of the MT19937 random word generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  // table geometry
  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int IDX_W         = $clog2(STATE_WORDS);
  localparam int WORD_W        = 32;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] MID_OFFS  = IDX_W'(MIDDLE_OFFSET);
  localparam logic [IDX_W-1:0] MID_WRAP  = IDX_W'(STATE_WORDS - MIDDLE_OFFSET);

  // generator constants
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

  // one draw request: word to twist and the two table words it needs
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] nxt_addr;
    logic [IDX_W-1:0] mid_addr;
  } req_t;

  // table write from the seeding sequencer
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

endpackage

>>> hw/rtl/mersenne_twister_generator_top.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// MT19937 random word generator with a 624-word state table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : draw items (valid/stall). An item with in_draw set asks for one
//            tempered 32-bit word; an item with in_draw clear gives nothing.
//   out_*  : result items (valid/stall), one out_random_word per draw.
//   cfg_*  : seed write (valid/ready); cfg_ready is always high. A write
//            restarts the sequence from the new seed.
// A draw passes through the request queue, the registered table reads and then the output buffer.
// Throughput: one word per cycle when not stalled; each word is twisted in place
//   as it is drawn, using the table's one write and two registered read ports.
// Reset and seed writes fill the table from the seed, each word by a multiply
//   step and then an add step; in_stall stays high meanwhile.
//   Reset loads the seed 5489.
// A stalled receiver fills the two-entry output buffer and the two-entry
//   request queue, after which in_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_draw,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed_value
);
  import mtg_pkg::*;

  logic    busy;
  mem_wr_t seed_wr;
  logic    q_push;
  req_t    q_data;
  logic    q_pop;
  req_t    q_head;
  logic    q_full;
  logic    q_not_empty;

  assign cfg_ready = 1'b1;

  mtg_seeder u_seeder (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_seed_value (cfg_seed_value),
    .busy           (busy),
    .seed_wr        (seed_wr)
  );

  mtg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_draw  (in_draw),
    .in_stall (in_stall),
    .busy     (busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  mtg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  mtg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (q_not_empty),
    .req             (q_head),
    .req_pop         (q_pop),
    .seed_wr         (seed_wr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word)
  );

endmodule

>>> hw/rtl/mtg_seeder.sv
// ----------------------------------------------------------------------------
// mtg_seeder
// Holds the seed register and fills the state table from it, each word by a
// multiply step and then an add of the index.
// ----------------------------------------------------------------------------
module mtg_seeder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [31:0]     cfg_seed_value,
  output logic            busy,
  output mtg_pkg::mem_wr_t seed_wr
);
  import mtg_pkg::*;

  typedef enum logic [3:0] {
    SD_IDLE = 4'b0001,
    SD_LOAD = 4'b0010,
    SD_MUL  = 4'b0100,
    SD_ADD  = 4'b1000
  } seed_state_t;

  seed_state_t       state_r, state_nxt;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] prod_r;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  cnt_inc;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] sum;

  assign cnt_inc = cnt_r + IDX_W'(1);
  assign mix     = word_r ^ (word_r >> 30);
  assign sum     = prod_r + WORD_W'(cnt_inc);
  assign busy    = (state_r != SD_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    seed_wr   = '0;
    unique case (state_r)
      SD_IDLE: begin
        state_nxt = SD_IDLE;
      end
      SD_LOAD: begin
        seed_wr   = '{en: 1'b1, addr: '0, data: seed_r};
        word_nxt  = seed_r;
        cnt_nxt   = '0;
        state_nxt = SD_MUL;
      end
      SD_MUL: begin
        state_nxt = SD_ADD;
      end
      SD_ADD: begin
        seed_wr   = '{en: 1'b1, addr: cnt_inc, data: sum};
        word_nxt  = sum;
        cnt_nxt   = cnt_inc;
        state_nxt = (cnt_inc == LAST_IDX) ? SD_IDLE : SD_MUL;
      end
      default: state_nxt = SD_IDLE;
    endcase
  end

  // control state and seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SD_LOAD;
      seed_r  <= SEED_RESET;
    end else if (cfg_valid) begin
      state_r <= SD_LOAD;
      seed_r  <= cfg_seed_value;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: registered product before the add
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= INIT_MULT * mix;
  end

endmodule

>>> hw/rtl/mtg_front.sv
// ----------------------------------------------------------------------------
// mtg_front
// Accepts draw items, drops those without the draw bit and turns the rest
// into table requests with the index and its two partner addresses.
// ----------------------------------------------------------------------------
module mtg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_draw,
  output logic          in_stall,
  input  logic          busy,
  input  logic          q_full,
  output logic          q_push,
  output mtg_pkg::req_t q_data
);
  import mtg_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             accept;

  assign in_stall = busy | q_full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept & in_draw;

  // partner addresses, wrapped around the table
  assign idx_nxt         = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign q_data.idx      = idx_r;
  assign q_data.nxt_addr = idx_nxt;
  assign q_data.mid_addr = (idx_r < MID_WRAP) ? idx_r + MID_OFFS : idx_r - MID_WRAP;

  // read index, cleared while the table is seeded
  always_ff @(posedge clk) begin
    if (!rst_n || busy) begin
      idx_r <= '0;
    end else if (q_push) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> hw/rtl/mtg_queue.sv
// ----------------------------------------------------------------------------
// mtg_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module mtg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtg_pkg::req_t push_data,
  input  logic          pop,
  output mtg_pkg::req_t head,
  output logic          full,
  output logic          not_empty
);
  import mtg_pkg::*;

  req_t       buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign head      = buf_r[rd_ptr_r];
  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> hw/rtl/mtg_back.sv
// ----------------------------------------------------------------------------
// mtg_back
// Owns the state table: reads the two partner words, twists one word per
// request in place, tempers it and buffers results in a two-entry output.
// ----------------------------------------------------------------------------
module mtg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  mtg_pkg::req_t    req,
  output logic             req_pop,
  input  mtg_pkg::mem_wr_t seed_wr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_random_word
);
  import mtg_pkg::*;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [WORD_W-1:0] mem [STATE_WORDS];
  logic [WORD_W-1:0] nxt_q;
  logic [WORD_W-1:0] mid_q;
  logic [WORD_W-1:0] cur_r;
  logic              s1_valid_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] twist_word;
  mem_wr_t           wr;
  logic [WORD_W-1:0] obuf_r [2];
  logic              owr_ptr_r;
  logic              ord_ptr_r;
  logic [1:0]        ocnt_r;
  logic [1:0]        occ;
  logic              deq;
  logic              room;

  // twist of the current word
  assign y          = {cur_r[WORD_W-1], nxt_q[WORD_W-2:0]};
  assign twist_word = mid_q ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);

  // write port shared by seeding and twisting
  assign wr = seed_wr.en ? seed_wr
                         : mem_wr_t'{en: s1_valid_r, addr: s1_idx_r, data: twist_word};

  // table memory with registered reads
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    nxt_q <= mem[req.nxt_addr];
    mid_q <= mem[req.mid_addr];
  end

  // issue only when the output buffer has space for the result
  assign deq     = out_valid & ~out_stall;
  assign occ     = ocnt_r + {1'b0, s1_valid_r};
  assign room    = deq ? (occ <= 2'd2) : (occ <= 2'd1);
  assign req_pop = req_valid & room;

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req_pop;
    end
  end

  // current word follows the table, starting from word zero after seeding
  always_ff @(posedge clk) begin
    s1_idx_r <= req.idx;
    if (seed_wr.en && seed_wr.addr == '0) begin
      cur_r <= seed_wr.data;
    end else if (s1_valid_r) begin
      cur_r <= nxt_q;
    end
  end

  // output buffer
  assign out_valid       = (ocnt_r != 2'd0);
  assign out_random_word = obuf_r[ord_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= 1'b0;
      ord_ptr_r <= 1'b0;
      ocnt_r    <= 2'd0;
    end else begin
      if (s1_valid_r) owr_ptr_r <= ~owr_ptr_r;
      if (deq)        ord_ptr_r <= ~ord_ptr_r;
      ocnt_r <= ocnt_r + {1'b0, s1_valid_r} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) obuf_r[owr_ptr_r] <= temper(twist_word);
  end

endmodule

>>> hw/rtl/mtg_checker.sv
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module mtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_random_word,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_word))
    else $error("result changed while stalled");

  // a result only leaves when taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without being taken");

  // seeding after reset blocks draws
  a_reset_seed: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("draw accepted before seeding");

  // a seed write starts a new fill that blocks draws
  a_cfg_seed: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("draw accepted during reseeding");

endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (.*);

>>> tb/mersenne_twister_generator_top_tb.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top_tb
// Self-checking bench for the MT19937 random word generator. Draw items are
// offered with random gaps, results are taken with random stalls, and every
// word is compared against a known word or a local MT19937 table model. The
// seed register is rewritten between phases; one longer phase runs 200 draw
// items and the receiver holds off once long enough to fill the block.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 12;
  localparam int          RESET_CYCLES = 8;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          HOLD_AFTER   = 120;
  localparam int          SETTLE       = 6;
  localparam int          RAND_PHASES  = 4;
  localparam int          LONG_PHASE   = 1;
  localparam int          LONG_ITEMS   = 200;

  // generator constants for the local model
  localparam int          TBL_WORDS     = 624;
  localparam int          SHIFT_SPAN    = 397;
  localparam logic [31:0] SEED_MUL      = 32'd1812433253;
  localparam logic [31:0] TWIST_MASK    = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
  localparam logic [31:0] DEFAULT_SEED  = 32'd5489;
  localparam logic        DRAW_ON       = 1'b1;
  localparam logic        DRAW_OFF      = 1'b0;

  typedef enum logic {ROW_DRAW, ROW_SEED} row_kind_t;

  // one directed row: a draw item or a seed write, with an optional known word
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        known;
    logic [31:0] known_word;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_DRAW, 32'(DRAW_ON),  1'b1, 32'd3499211612},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b1, 32'd581869302},
    '{ROW_DRAW, 32'(DRAW_OFF), 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b1, 32'd3890346734},
    '{ROW_DRAW, 32'(DRAW_OFF), 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_OFF), 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_SEED, DEFAULT_SEED,  1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b1, 32'd3499211612},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b1, 32'd581869302},
    '{ROW_SEED, 32'h0000_0000, 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_OFF), 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_SEED, 32'hffff_ffff, 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_OFF), 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_SEED, 32'h8000_0001, 1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0},
    '{ROW_DRAW, 32'(DRAW_ON),  1'b0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_draw;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_random_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed_value;

  // local generator state
  logic [31:0] mt_words [TBL_WORDS];
  int          draw_pos;

  logic [31:0] expected_words [$];
  logic [31:0] want_word;
  int          wrong_words   = 0;
  int          words_checked = 0;
  int          draws_sent    = 0;
  int          seeds_written = 0;
  int          idle_cycles   = 0;
  logic        tx_calm       = 1'b0;
  logic        rx_calm       = 1'b0;

  mersenne_twister_generator_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_draw         (in_draw),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_seed_value  (cfg_seed_value)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // fill the table from a seed and restart at word zero
  function automatic void seed_table(input logic [31:0] seed);
    logic [31:0] prev;
    mt_words[0] = seed;
    for (int k = 1; k < TBL_WORDS; k++) begin
      prev        = mt_words[k-1];
      mt_words[k] = SEED_MUL * (prev ^ (prev >> 30)) + 32'(k);
    end
    draw_pos = 0;
  endfunction

  // regenerate all words in place
  function automatic void twist_table();
    logic [31:0] y;
    logic [31:0] v;
    int          nxt;
    int          mid;
    for (int k = 0; k < TBL_WORDS; k++) begin
      nxt = (k + 1) % TBL_WORDS;
      mid = (k + SHIFT_SPAN) % TBL_WORDS;
      y   = {mt_words[k][31], mt_words[nxt][30:0]};
      v   = mt_words[mid] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_MASK;
      end
      mt_words[k] = v;
    end
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_MASK_B);
    y = y ^ ((y << 15) & TEMPER_MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // word produced by the next draw
  function automatic logic [31:0] next_word();
    logic [31:0] w;
    if (draw_pos == 0) begin
      twist_table();
    end
    w        = temper_word(mt_words[draw_pos]);
    draw_pos = (draw_pos + 1) % TBL_WORDS;
    return w;
  endfunction

  // offer one item and hold it until it is accepted
  task automatic offer_draw(input logic draw_bit, input logic known,
                            input logic [31:0] known_word);
    int          gap;
    logic [31:0] w;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_draw  <= draw_bit;
    do @(posedge clk); while (in_stall);
    draws_sent++;
    if (draw_bit) begin
      w = next_word();
      expected_words.insert(expected_words.size(), known ? known_word : w);
    end
  endtask

  // reseed once the block has gone quiet
  task automatic write_seed(input logic [31:0] seed);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_seed_value <= seed;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seed_table(seed);
    seeds_written++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("random_word: expected nothing, got %h", out_random_word);
        wrong_words++;
      end else begin
        want_word = expected_words.pop_front();
        if (out_random_word !== want_word) begin
          $error("random_word: expected %h, got %h", want_word, out_random_word);
          wrong_words++;
        end
        words_checked++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stalls per result, one long hold-off
  initial begin : receiver
    int   wait_cycles;
    int   taken;
    logic held;
    taken     = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        wait_cycles = HOLD_CYCLES;
        held        = 1'b1;
      end else begin
        wait_cycles = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // stimulus
  initial begin : driver
    int   items;
    logic bit_val;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_draw        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_seed_value = 32'd0;
    seed_table(DEFAULT_SEED);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_SEED) begin
        write_seed(DIRECTED[r].value);
      end else begin
        offer_draw(DIRECTED[r].value[0], DIRECTED[r].known, DIRECTED[r].known_word);
      end
    end

    // random phases, each from a fresh seed; one runs longer than the rest
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_seed($urandom);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      items   = (p == LONG_PHASE) ? LONG_ITEMS : $urandom_range(40, 80);
      for (int i = 0; i < items; i++) begin
        bit_val = ($urandom_range(0, 7) != 0);
        offer_draw(bit_val, 1'b0, 32'd0);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d draw items and %0d checked words over %0d seed writes",
             draws_sent, words_checked, seeds_written);
    $display("seeds 0 and all-ones, reseeding between phases, one %0d-cycle receiver hold",
             HOLD_CYCLES);
    if (wrong_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_seeder.sv
hw/rtl/mtg_front.sv
hw/rtl/mtg_queue.sv
hw/rtl/mtg_back.sv
hw/rtl/mersenne_twister_generator_top.sv
hw/rtl/mtg_checker.sv
tb/mersenne_twister_generator_top_tb.sv
